// ===== rtl/core/rmh_pkg.sv =====
// ----------------------------------------------------------------------------
// rmh_pkg
// shared types, codes and defaults of the two-heap running median block
// ----------------------------------------------------------------------------
package rmh_pkg;

    localparam int CAPACITY_DEF   = 1024;
    localparam int VALUE_BITS_DEF = 32;
    localparam int FUNC_W         = 2;
    localparam int FIELD_W        = 32;
    localparam int STATUS_W       = 2;
    localparam int QUEUE_DEPTH    = 4;

    typedef enum logic [FUNC_W-1:0] {
        OP_INSERT = 2'd0,
        OP_TAKE   = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    localparam logic HEAP_LOWER = 1'b0;
    localparam logic HEAP_UPPER = 1'b1;

    // one heap primitive of an operation's plan
    typedef struct packed {
        logic valid;
        logic is_rm;     // remove top, otherwise insert
        logic heap;
        logic from_top;  // insert the top captured by the last remove
    } uop_t;

    typedef enum logic [3:0] {
        E_IDLE,
        E_PEEK,
        E_NEXT,
        R_LAST,
        R_X,
        R_L,
        R_R,
        R_CMP,
        I_P,
        I_CMP,
        E_RESP
    } eng_state_t;

endpackage

// ===== rtl/core/rmh_ram.sv =====
// ----------------------------------------------------------------------------
// rmh_ram
// generic single-write single-read ram with registered read data
// ----------------------------------------------------------------------------
module rmh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/rmh_fifo.sv =====
// ----------------------------------------------------------------------------
// rmh_fifo
// short queue between the front and the heap engine
// ----------------------------------------------------------------------------
module rmh_fifo #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wptr_reg;
    logic [PW-1:0]    rptr_reg;
    logic [CNW-1:0]   fill_reg;

    assign full     = (fill_reg == CNW'(DEPTH));
    assign empty    = (fill_reg == '0);
    assign pop_data = slot_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            slot_reg[wptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wptr_reg <= (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (pop && !empty)
            begin
                rptr_reg <= (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            case ({push && !full, pop && !empty})
                2'b10:   fill_reg <= fill_reg + 1'b1;
                2'b01:   fill_reg <= fill_reg - 1'b1;
                default: fill_reg <= fill_reg;
            endcase
        end
    end

endmodule

// ===== rtl/core/rmh_front.sv =====
// ----------------------------------------------------------------------------
// rmh_front
// accepts items, drops unused codes, narrows the value and queues the rest
// ----------------------------------------------------------------------------
module rmh_front
    import rmh_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [FUNC_W-1:0]            func,
    input  logic signed [FIELD_W-1:0]    value,
    input  logic                         q_full,
    output logic                         q_push,
    output logic [FUNC_W+VALUE_BITS-1:0] q_data
);

    localparam int MW = (VALUE_BITS > FIELD_W) ? VALUE_BITS : FIELD_W;

    logic signed [MW-1:0] value_wide;

    // the upper bits drop out, the stored value is signed at VALUE_BITS
    assign value_wide = MW'(value);
    assign in_ready   = !q_full;
    assign q_push     = in_valid && !q_full &&
                        (func == OP_INSERT || func == OP_TAKE || func == OP_CLEAR);
    assign q_data     = {func, value_wide[VALUE_BITS-1:0]};

endmodule

// ===== rtl/core/rmh_engine.sv =====
// ----------------------------------------------------------------------------
// rmh_engine
// heap sequencer: plans each operation as heap primitives and runs them
// ----------------------------------------------------------------------------
module rmh_engine
    import rmh_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_empty,
    input  logic [FUNC_W+VALUE_BITS-1:0] q_data,
    output logic                         q_pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [FIELD_W-1:0]           median,
    output logic [STATUS_W-1:0]          status
);

    localparam int HALF = (CAPACITY + 1) / 2;
    localparam int AW   = (HALF > 1) ? $clog2(HALF) : 1;
    localparam int CW   = $clog2(HALF + 1);
    localparam int IW   = CW + 1;
    localparam int TW   = $clog2(CAPACITY + 1);
    localparam int MW   = (VALUE_BITS > FIELD_W) ? VALUE_BITS : FIELD_W;

    eng_state_t state_reg, state_next;

    logic [CW-1:0]                lc_reg, uc_reg;
    uop_t                         ops_reg [3];
    logic                         is_take_reg;
    logic                         heap_reg;
    logic signed [VALUE_BITS-1:0] v_reg, top_reg, med_reg, x_reg, lv_reg, ins_val_reg;
    logic                         rv_valid_reg;
    logic [IW-1:0]                i_reg;
    logic [CW-1:0]                cnt_reg;
    status_t                      resp_reg;
    logic                         out_valid_reg;
    logic [FIELD_W-1:0]           median_reg;
    logic [STATUS_W-1:0]          status_reg;

    logic [TW-1:0]                total;
    logic                         peek_heap;
    op_t                          q_op;
    logic signed [VALUE_BITS-1:0] q_val;
    logic signed [VALUE_BITS-1:0] rdata, rdata_l, rdata_u;
    logic                         rd_en, rd_heap, wr_en;
    logic [AW-1:0]                rd_addr, wr_addr;
    logic [VALUE_BITS-1:0]        wr_data;
    logic [IW-1:0]                l_idx, r_idx, p_idx, cnt_w;
    logic                         is_max, l_out, r_in, best_l, best_r, ins_up;
    logic signed [VALUE_BITS-1:0] best_lx;
    logic                         slot_free;
    logic [CW-1:0]                cur_cnt;
    logic [MW-1:0]                med_wide;

    function automatic logic above(input logic signed [VALUE_BITS-1:0] a,
                                   input logic signed [VALUE_BITS-1:0] b,
                                   input logic mx);
        above = mx ? (a > b) : (a < b);
    endfunction

    assign total     = TW'(lc_reg) + TW'(uc_reg);
    assign peek_heap = total[0] ? HEAP_LOWER : HEAP_UPPER;
    assign q_op      = op_t'(q_data[FUNC_W+VALUE_BITS-1:VALUE_BITS]);
    assign q_val     = q_data[VALUE_BITS-1:0];
    assign rdata     = heap_reg ? rdata_u : rdata_l;
    assign is_max    = (heap_reg == HEAP_LOWER);
    assign cnt_w     = IW'(cnt_reg);
    assign l_idx     = {i_reg[IW-2:0], 1'b1};
    assign r_idx     = l_idx + 1'b1;
    assign p_idx     = (i_reg - 1'b1) >> 1;
    assign l_out     = (l_idx >= cnt_w);
    assign r_in      = (r_idx < cnt_w);
    assign best_l    = above(lv_reg, x_reg, is_max);
    assign best_lx   = best_l ? lv_reg : x_reg;
    assign best_r    = rv_valid_reg && above(rdata, best_lx, is_max);
    assign ins_up    = above(ins_val_reg, rdata, is_max);
    assign slot_free = !out_valid_reg || out_ready;
    assign cur_cnt   = ops_reg[0].heap ? uc_reg : lc_reg;
    assign med_wide  = MW'($unsigned(med_reg));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            E_IDLE:
            begin
                if (!q_empty)
                begin
                    case (q_op)
                        OP_TAKE:
                            state_next = (lc_reg == '0) ? E_RESP : E_NEXT;
                        OP_INSERT:
                        begin
                            if (total >= TW'(CAPACITY))
                                state_next = E_RESP;
                            else if (total[0] ? (lc_reg != '0) : (uc_reg != '0))
                                state_next = E_PEEK;
                            else
                                state_next = E_NEXT;
                        end
                        default: state_next = E_IDLE;
                    endcase
                end
            end
            E_PEEK: state_next = E_NEXT;
            E_NEXT:
            begin
                if (ops_reg[0].valid)
                    state_next = ops_reg[0].is_rm ? R_LAST : I_P;
                else
                    state_next = is_take_reg ? E_RESP : E_IDLE;
            end
            R_LAST: state_next = R_X;
            R_X:    state_next = R_L;
            R_L:    state_next = l_out ? E_NEXT : R_R;
            R_R:    state_next = R_CMP;
            R_CMP:  state_next = (best_r || best_l) ? R_L : E_NEXT;
            I_P:    state_next = (i_reg == '0) ? E_NEXT : I_CMP;
            I_CMP:  state_next = ins_up ? I_P : E_NEXT;
            E_RESP: state_next = slot_free ? E_IDLE : E_RESP;
            default: state_next = E_IDLE;
        endcase
    end

    // memory and queue controls
    always_comb
    begin
        q_pop   = 1'b0;
        rd_en   = 1'b0;
        rd_heap = heap_reg;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = i_reg[AW-1:0];
        wr_data = x_reg;
        case (state_reg)
            E_IDLE:
            begin
                q_pop   = !q_empty;
                rd_heap = peek_heap;
                rd_en   = !q_empty && (q_op == OP_INSERT);
            end
            E_NEXT:
            begin
                rd_heap = ops_reg[0].heap;
                rd_en   = ops_reg[0].valid && ops_reg[0].is_rm;
            end
            R_LAST:
            begin
                rd_en   = 1'b1;
                rd_addr = cnt_reg[AW-1:0];
            end
            R_L:
            begin
                rd_en   = !l_out;
                rd_addr = l_idx[AW-1:0];
                wr_en   = l_out;
            end
            R_R:
            begin
                rd_en   = r_in;
                rd_addr = r_idx[AW-1:0];
            end
            R_CMP:
            begin
                wr_en   = 1'b1;
                wr_data = best_r ? rdata : best_lx;
            end
            I_P:
            begin
                rd_en   = (i_reg != '0);
                rd_addr = p_idx[AW-1:0];
                wr_en   = (i_reg == '0);
                wr_data = ins_val_reg;
            end
            I_CMP:
            begin
                wr_en   = 1'b1;
                wr_data = ins_up ? rdata : ins_val_reg;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            lc_reg    <= '0;
            uc_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == E_IDLE && !q_empty && q_op == OP_CLEAR)
            begin
                lc_reg <= '0;
                uc_reg <= '0;
            end
            else if (state_reg == E_NEXT && ops_reg[0].valid)
            begin
                if (ops_reg[0].heap == HEAP_UPPER)
                    uc_reg <= ops_reg[0].is_rm ? uc_reg - 1'b1 : uc_reg + 1'b1;
                else
                    lc_reg <= ops_reg[0].is_rm ? lc_reg - 1'b1 : lc_reg + 1'b1;
            end
        end
    end

    // plan and datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            E_IDLE:
            begin
                v_reg       <= q_val;
                heap_reg    <= peek_heap;
                is_take_reg <= (q_op == OP_TAKE);
                ops_reg[0]  <= '0;
                ops_reg[1]  <= '0;
                ops_reg[2]  <= '0;
                if (q_op == OP_TAKE)
                begin
                    resp_reg   <= (lc_reg == '0) ? ST_EMPTY : ST_OK;
                    ops_reg[0] <= '{1'b1, 1'b1, HEAP_LOWER, 1'b0};
                    if (!total[0] && uc_reg != '0)
                    begin
                        ops_reg[1] <= '{1'b1, 1'b1, HEAP_UPPER, 1'b0};
                        ops_reg[2] <= '{1'b1, 1'b0, HEAP_LOWER, 1'b1};
                    end
                end
                else
                begin
                    resp_reg   <= ST_FULL;
                    ops_reg[0] <= '{1'b1, 1'b0, total[0] ? HEAP_UPPER : HEAP_LOWER, 1'b0};
                end
            end
            E_PEEK:
            begin
                // value crosses the top of the other heap: swap it through
                if (heap_reg == HEAP_LOWER ? (v_reg < rdata) : (v_reg > rdata))
                begin
                    ops_reg[0] <= '{1'b1, 1'b1, heap_reg, 1'b0};
                    ops_reg[1] <= '{1'b1, 1'b0, heap_reg, 1'b0};
                    ops_reg[2] <= '{1'b1, 1'b0, !heap_reg, 1'b1};
                end
            end
            E_NEXT:
            begin
                ops_reg[0]  <= ops_reg[1];
                ops_reg[1]  <= ops_reg[2];
                ops_reg[2]  <= '0;
                heap_reg    <= ops_reg[0].heap;
                cnt_reg     <= cur_cnt - 1'b1;
                i_reg       <= IW'(cur_cnt);
                ins_val_reg <= ops_reg[0].from_top ? top_reg : v_reg;
            end
            R_LAST:
            begin
                top_reg <= rdata;
                if (is_take_reg && heap_reg == HEAP_LOWER)
                    med_reg <= rdata;
            end
            R_X:
            begin
                x_reg <= rdata;
                i_reg <= '0;
            end
            R_R:
            begin
                lv_reg       <= rdata;
                rv_valid_reg <= r_in;
            end
            R_CMP:
            begin
                if (best_r)
                    i_reg <= r_idx;
                else if (best_l)
                    i_reg <= l_idx;
            end
            I_CMP:
            begin
                if (ins_up)
                    i_reg <= p_idx;
            end
            default:
            begin
                i_reg <= i_reg;
            end
        endcase
    end

    // result register, decoupled from the sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == E_RESP && slot_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == E_RESP && slot_free)
        begin
            median_reg <= (resp_reg == ST_OK) ? med_wide[FIELD_W-1:0] : '0;
            status_reg <= resp_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign median    = median_reg;
    assign status    = status_reg;

    rmh_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (HALF)
    ) u_lower_ram (
        .clk   (clk),
        .we    (wr_en && heap_reg == HEAP_LOWER),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en && rd_heap == HEAP_LOWER),
        .raddr (rd_addr),
        .rdata (rdata_l)
    );

    rmh_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (HALF)
    ) u_upper_ram (
        .clk   (clk),
        .we    (wr_en && heap_reg == HEAP_UPPER),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en && rd_heap == HEAP_UPPER),
        .raddr (rd_addr),
        .rdata (rdata_u)
    );

endmodule

// ===== rtl/core/running_median_two_heaps.sv =====
// a clear is done in the idle state, an insert peeks the other heap's top if that heap holds
// values and runs its heap passes, a take runs its passes and loads the result register once
// it is free; each pass is a dispatch state, then a remove runs R_LAST, R_X, then R_L, R_R,
// R_CMP per level, an insert I_P, I_CMP per level; one item at a time in the sequencer, up to
// three passes per item over heaps of log2(CAPACITY/2) levels; a four-entry queue takes items
// meanwhile; reset: counts and control clear at once, heap rams are not cleared
// ----------------------------------------------------------------------------
// running_median_two_heaps
// running median over a max-heap of the lower half and a min-heap of the upper
// ----------------------------------------------------------------------------
module running_median_two_heaps
    import rmh_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [FUNC_W-1:0]         func,
    input  logic signed [FIELD_W-1:0] value,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [FIELD_W-1:0] median,
    output logic [STATUS_W-1:0]       status
);

    localparam int QW = FUNC_W + VALUE_BITS;

    logic          q_full, q_push, q_empty, q_pop;
    logic [QW-1:0] q_in, q_out;

    rmh_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .func     (func),
        .value    (value),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    rmh_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    rmh_engine #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (q_out),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .median    (median),
        .status    (status)
    );

endmodule

// ===== rtl/core/rmh_checker.sv =====
// ----------------------------------------------------------------------------
// rmh_checker
// port-level checks of the running median block
// ----------------------------------------------------------------------------
module rmh_checker
    import rmh_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic [FUNC_W-1:0]         func,
    input logic signed [FIELD_W-1:0] value,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic signed [FIELD_W-1:0] median,
    input logic [STATUS_W-1:0]       status
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(median) && $stable(status))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK || status == ST_EMPTY || status == ST_FULL))
        else $error("bad status code");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> median == '0)
        else $error("error result with nonzero median");

    // nothing is offered while reset is held, checked at each edge where reset was already low before
    a_reset_quiet: assert property (@(posedge clk) !rst_n && $past(!rst_n) |-> !out_valid)
        else $error("result shown during reset");

endmodule

bind running_median_two_heaps rmh_checker u_rmh_checker (.*);

// ===== tb/running_median_two_heaps_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// running_median_two_heaps_checker
// watches both channels, keeps its own pair of heaps and compares every result
// ----------------------------------------------------------------------------
module running_median_two_heaps_checker
    import rmh_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  logic [FUNC_W-1:0]         func,
    input  logic signed [FIELD_W-1:0] value,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic signed [FIELD_W-1:0] median,
    input  logic [STATUS_W-1:0]       status,
    output int                        fail_count,
    output int                        pending
);

    localparam int HALF = (CAPACITY + 1) / 2;

    typedef struct packed {
        logic signed [FIELD_W-1:0] median;
        status_t                   status;
    } answer_t;

    logic signed [FIELD_W-1:0] lo_heap [HALF];
    logic signed [FIELD_W-1:0] hi_heap [HALF];
    int lo_n, hi_n, total_n;
    answer_t answer_q[$];

    // true when a belongs above b; max-heap for the lower half
    function automatic bit ranks_above(logic signed [FIELD_W-1:0] a,
                                       logic signed [FIELD_W-1:0] b, bit is_max);
        return is_max ? (a > b) : (a < b);
    endfunction

    task automatic heap_push(bit is_max, logic signed [FIELD_W-1:0] v);
        int i;
        int p;
        logic signed [FIELD_W-1:0] t;
        i = is_max ? lo_n : hi_n;
        if (i >= HALF) return;
        if (is_max) begin lo_heap[i] = v; lo_n++; end
        else begin hi_heap[i] = v; hi_n++; end
        while (i > 0) begin
            p = (i - 1) / 2;
            if (is_max) begin
                if (!ranks_above(lo_heap[i], lo_heap[p], 1)) break;
                t = lo_heap[i]; lo_heap[i] = lo_heap[p]; lo_heap[p] = t;
            end else begin
                if (!ranks_above(hi_heap[i], hi_heap[p], 0)) break;
                t = hi_heap[i]; hi_heap[i] = hi_heap[p]; hi_heap[p] = t;
            end
            i = p;
        end
    endtask

    task automatic heap_pop(bit is_max);
        int n;
        int i;
        int l;
        int r;
        int best;
        logic signed [FIELD_W-1:0] t;
        n = is_max ? lo_n : hi_n;
        if (n == 0) return;
        n--;
        if (is_max) begin lo_n = n; lo_heap[0] = lo_heap[n]; end
        else begin hi_n = n; hi_heap[0] = hi_heap[n]; end
        i = 0;
        forever begin
            l = 2 * i + 1;
            r = l + 1;
            best = i;
            if (is_max) begin
                if (l < n && ranks_above(lo_heap[l], lo_heap[best], 1)) best = l;
                if (r < n && ranks_above(lo_heap[r], lo_heap[best], 1)) best = r;
                if (best == i) break;
                t = lo_heap[i]; lo_heap[i] = lo_heap[best]; lo_heap[best] = t;
            end else begin
                if (l < n && ranks_above(hi_heap[l], hi_heap[best], 0)) best = l;
                if (r < n && ranks_above(hi_heap[r], hi_heap[best], 0)) best = r;
                if (best == i) break;
                t = hi_heap[i]; hi_heap[i] = hi_heap[best]; hi_heap[best] = t;
            end
            i = best;
        end
    endtask

    task automatic apply_op(logic [FUNC_W-1:0] f, logic signed [FIELD_W-1:0] v);
        logic signed [FIELD_W-1:0] top;
        answer_t a;
        case (f)
            OP_CLEAR: begin
                lo_n = 0; hi_n = 0; total_n = 0;
            end
            OP_INSERT: begin
                if (total_n >= CAPACITY) begin
                    a.median = '0; a.status = ST_FULL;
                    answer_q = {answer_q, a};
                end else begin
                    if (total_n % 2 == 1) begin
                        if (lo_n > 0 && v < lo_heap[0]) begin
                            top = lo_heap[0];
                            heap_pop(1); heap_push(1, v); heap_push(0, top);
                        end else heap_push(0, v);
                    end else begin
                        if (hi_n > 0 && v > hi_heap[0]) begin
                            top = hi_heap[0];
                            heap_pop(0); heap_push(0, v); heap_push(1, top);
                        end else heap_push(1, v);
                    end
                    total_n = lo_n + hi_n;
                end
            end
            OP_TAKE: begin
                if (total_n == 0 || lo_n == 0) begin
                    a.median = '0; a.status = ST_EMPTY;
                end else begin
                    a.median = lo_heap[0]; a.status = ST_OK;
                    heap_pop(1);
                    if (total_n % 2 == 0 && hi_n > 0) begin
                        top = hi_heap[0];
                        heap_pop(0); heap_push(1, top);
                    end
                    total_n = lo_n + hi_n;
                end
                answer_q = {answer_q, a};
            end
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n) begin
        answer_t exp_a;
        if (!rst_n) begin
            lo_n = 0; hi_n = 0; total_n = 0;
            fail_count <= 0;
            answer_q.delete();
        end else begin
            if (out_valid && out_ready) begin
                if (answer_q.size() == 0) begin
                    $display("%0t: unexpected result median=%0d status=%0d",
                             $time, median, status);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_a = answer_q.pop_front();
                    if (median !== exp_a.median || status !== exp_a.status) begin
                        $display({"%0t: mismatch expected median=%0d status=%0d,",
                                  " got median=%0d status=%0d"},
                                 $time, exp_a.median, exp_a.status, median, status);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_valid && in_ready) apply_op(func, value);
        end
        pending <= answer_q.size();
    end

endmodule

// ===== tb/running_median_two_heaps_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// running_median_two_heaps_test
// drives random and directed insert, take, clear, code 3 transfers, random gaps
// and a long output stall; the checker predicts and compares each result
// ----------------------------------------------------------------------------
module running_median_two_heaps_test;
    import rmh_pkg::*;

    localparam int CAP = CAPACITY_DEF;
    localparam longint CYCLE_LIMIT = 2000000;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic [FUNC_W-1:0]         func;
    logic signed [FIELD_W-1:0] value;
    logic                      out_valid;
    logic                      out_ready;
    logic signed [FIELD_W-1:0] median;
    logic [STATUS_W-1:0]       status;
    int                        fail_count;
    int                        pending;
    longint                    cycles;
    bit                        hold_off;

    running_median_two_heaps dut (.*);

    running_median_two_heaps_checker #(.CAPACITY(CAP)) checker_i (.*);

    initial begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial begin
        cycles = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    // one transfer on the input channel, then a random gap
    task automatic send_op(logic [FUNC_W-1:0] f, logic signed [FIELD_W-1:0] v, bit no_gap);
        int g;
        in_valid <= 1'b1;
        func <= f;
        value <= v;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        g = no_gap ? 0 : gap_len();
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    function automatic logic signed [FIELD_W-1:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $signed($urandom_range(0, 20)) - 10;
            default: return $signed($urandom());
        endcase
    endfunction

    // receiver: random stalls, one long hold-off when asked
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) out_ready <= 1'b0;
        else if (hold_off) out_ready <= 1'b0;
        else out_ready <= ($urandom_range(0, 3) != 0);
    end

    initial begin
        int i;
        int r;
        int phase;
        hold_off = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = OP_INSERT;
        value = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty take, extremes, code 3, clear
        send_op(OP_TAKE, 0, 0);
        send_op(OP_INSERT, 32'sh7fffffff, 0);
        send_op(OP_INSERT, 32'sh80000000, 0);
        send_op(OP_INSERT, 0, 0);
        send_op(OP_INSERT, -1, 0);
        send_op(OP_INSERT, 32'sh55555555, 0);
        send_op(OP_INSERT, 32'shaaaaaaaa, 0);
        send_op(2'd3, 32'sh12345678, 0);
        send_op(OP_TAKE, 0, 0);
        send_op(OP_TAKE, -1, 0);
        send_op(OP_CLEAR, 0, 0);
        send_op(OP_TAKE, 0, 0);
        send_op(OP_INSERT, 5, 0);
        send_op(OP_INSERT, 5, 0);
        send_op(OP_TAKE, 0, 0);
        send_op(OP_TAKE, 0, 0);
        send_op(OP_TAKE, 0, 0);

        // long receiver hold-off while takes pile up
        for (i = 0; i < 8; i++) send_op(OP_INSERT, rand_value(), 1);
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            for (i = 0; i < 10; i++) send_op(OP_TAKE, 0, 1);
        join

        // random mix, biased by phase toward growth or drain
        for (i = 0; i < 365; i++) begin
            phase = (i / 50) % 2;
            r = $urandom_range(0, 99);
            if (r < 2) send_op(OP_CLEAR, 0, 0);
            else if (r < 4) send_op(2'd3, $signed($urandom()), 0);
            else if (r < (phase ? 40 : 70)) send_op(OP_INSERT, rand_value(), 0);
            else send_op(OP_TAKE, $signed($urandom()), 0);
        end
        in_valid <= 1'b0;

        // let the count of outstanding results catch up with the last transfer
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/rmh_pkg.sv
rtl/core/rmh_ram.sv
rtl/core/rmh_fifo.sv
rtl/core/rmh_front.sv
rtl/core/rmh_engine.sv
rtl/core/running_median_two_heaps.sv
rtl/core/rmh_checker.sv
tb/running_median_two_heaps_checker.sv
tb/running_median_two_heaps_test.sv
